// ===== src/bpa_pkg.sv =====
// Shared constants and codes of the buddy page allocator.
package bpa_pkg;

	localparam int PAGE_COUNT = 1024;
	localparam int PAGE_SHIFT = 12;
	localparam int PAGE_BYTES = 1 << PAGE_SHIFT;
	localparam int ORDER_COUNT = 11;

	localparam int PAGE_W = 10;
	localparam int CNT_W = PAGE_W + 1;
	localparam int ORD_W = 4;
	localparam int REQ_W = 23;
	localparam int BLK_W = PAGE_SHIFT + ORDER_COUNT + 1;
	localparam int STAT_W = 2;
	localparam int QUOTA_W = 32;

	localparam logic [ORD_W-1:0] TOP_ORDER = ORD_W'(ORDER_COUNT - 1);

	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOFREE = 2'd1;
	localparam logic [STAT_W-1:0] ST_QUOTA = 2'd2;
	localparam logic [STAT_W-1:0] ST_DFREE = 2'd3;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE = 1'b1;

endpackage

// ===== src/buddy_page_allocator_unit.sv =====
// Binary buddy page allocator with per-order free lists kept in page memories.
// An allocation takes longer with each split level and each page taken; a free takes longer
// with each page freed and each merge level; refusals finish without a page sweep.
// Throughput: one word at a time; the per-page sweep over the free-flag memory dominates.
// Reset: a clearing pass over all 1024 pages writes the page memories; busy is high meanwhile.
// Each result word is shown for one cycle on done; the receiver cannot stall.
module buddy_page_allocator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          func,
	input  logic [bpa_pkg::REQ_W-1:0]     request_bytes,
	input  logic [bpa_pkg::PAGE_W-1:0]    block_index,
	input  logic                          use_quota,
	input  logic                          quota_limit_we,
	input  logic [bpa_pkg::QUOTA_W-1:0]   quota_limit_bytes,
	output logic                          done,
	output logic [bpa_pkg::STAT_W-1:0]    status,
	output logic [bpa_pkg::PAGE_W-1:0]    result_index,
	output logic [bpa_pkg::ORD_W-1:0]     result_order,
	output logic [bpa_pkg::CNT_W-1:0]     free_pages
);
	import bpa_pkg::*;

	localparam logic [4:0] S_CLR    = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_CHK    = 5'd2;
	localparam logic [4:0] S_AHEAD  = 5'd3;
	localparam logic [4:0] S_ASPLIT = 5'd4;
	localparam logic [4:0] S_ASPL1  = 5'd5;
	localparam logic [4:0] S_ASPL2  = 5'd6;
	localparam logic [4:0] S_ASPL3  = 5'd7;
	localparam logic [4:0] S_ASW0   = 5'd8;
	localparam logic [4:0] S_F0     = 5'd9;
	localparam logic [4:0] S_F1     = 5'd10;
	localparam logic [4:0] S_SWRD   = 5'd11;
	localparam logic [4:0] S_SWWR   = 5'd12;
	localparam logic [4:0] S_SWEND  = 5'd13;
	localparam logic [4:0] S_M0     = 5'd14;
	localparam logic [4:0] S_M1     = 5'd15;
	localparam logic [4:0] S_M2     = 5'd16;
	localparam logic [4:0] S_M3     = 5'd17;
	localparam logic [4:0] S_M4     = 5'd18;
	localparam logic [4:0] S_MEND   = 5'd19;
	localparam logic [4:0] S_FDONE  = 5'd20;
	localparam logic [4:0] S_RM0    = 5'd21;
	localparam logic [4:0] S_RM1    = 5'd22;
	localparam logic [4:0] S_AD0    = 5'd23;
	localparam logic [4:0] S_AD1    = 5'd24;
	localparam logic [4:0] S_AD2    = 5'd25;
	localparam logic [4:0] S_FIN    = 5'd26;

	// Page memories: free flag, block order, next and previous list links.
	logic                fre_mem [PAGE_COUNT];
	logic [ORD_W-1:0]    ord_mem [PAGE_COUNT];
	logic [PAGE_W-1:0]   nxt_mem [PAGE_COUNT];
	logic [PAGE_W-1:0]   prv_mem [PAGE_COUNT];
	logic                fre_rd;
	logic [ORD_W-1:0]    ord_rd;
	logic [PAGE_W-1:0]   nxt_rd;
	logic [PAGE_W-1:0]   prv_rd;

	logic                f_we, o_we, n_we, v_we;
	logic [PAGE_W-1:0]   f_wa, o_wa, n_wa, v_wa;
	logic                f_wd;
	logic [ORD_W-1:0]    o_wd;
	logic [PAGE_W-1:0]   n_wd, v_wd;
	logic [PAGE_W-1:0]   pi_ra, lk_ra;

	// Control and working registers.
	logic [4:0]          state_q, ret_q;
	logic                func_q, quota_q;
	logic [ORD_W-1:0]    ord_q, lo_q, lord_q;
	logic                lfree_q;
	logic [PAGE_W-1:0]   lh_q, rh_q, p_q, ln_q;
	logic [CNT_W-1:0]    cnt_q, alloc_q;
	logic [QUOTA_W-1:0]  used_q, limit_q;
	logic [ORDER_COUNT-1:0] hv_q;
	logic [PAGE_W-1:0]   head_q [ORDER_COUNT];
	logic [STAT_W-1:0]   st_q;
	logic [PAGE_W-1:0]   ridx_q;
	logic [ORD_W-1:0]    rord_q;
	logic                done_q;
	logic [STAT_W-1:0]   status_q;
	logic [PAGE_W-1:0]   result_index_q;
	logic [ORD_W-1:0]    result_order_q;
	logic [CNT_W-1:0]    free_pages_q;

	// Derived values.
	logic [REQ_W-1:0]    req_m1;
	logic [CNT_W-1:0]    req_pg;
	logic [ORD_W-1:0]    req_ord;
	logic [ORD_W-1:0]    idx_n, sel_ord;
	logic [BLK_W-1:0]    blk_b;
	logic [QUOTA_W-1:0]  q_room;
	logic                q_fail;
	logic                stop_ok;
	logic [ORD_W-1:0]    stop_o;
	logic [CNT_W-1:0]    blk_n, sw_a;
	logic                mg_odd;
	logic [PAGE_W-1:0]   mg_lh;
	logic [CNT_W-1:0]    mg_rh;
	logic [PAGE_W-1:0]   head_cur;

	assign head_cur = head_q[lo_q];

	// Request order: bit length of (pages needed minus one), taken from request_bytes - 1.
	always_comb begin
		req_m1 = (request_bytes == '0) ? '0 : request_bytes - REQ_W'(1);
		req_pg = req_m1[REQ_W-1:PAGE_SHIFT];
		req_ord = '0;
		for (int b = 0; b < CNT_W; b++) begin
			if (req_pg[b]) req_ord = ORD_W'(b + 1);
		end
	end

	// Block size in bytes for the order in use this cycle.
	assign idx_n = (ord_rd >= ORD_W'(ORDER_COUNT)) ? TOP_ORDER : ord_rd;
	always_comb begin
		if (state_q == S_CHK) sel_ord = ord_q;
		else if (state_q == S_F1) sel_ord = idx_n;
		else sel_ord = lo_q;
	end
	assign blk_b = BLK_W'(PAGE_BYTES) << sel_ord;
	assign q_room = limit_q - used_q;
	assign q_fail = quota_q && ((limit_q < used_q) || (QUOTA_W'(blk_b) > q_room));

	// Smallest non-empty order at or above the request.
	always_comb begin
		stop_ok = 1'b0;
		stop_o = '0;
		for (int o = ORDER_COUNT - 1; o >= 0; o--) begin
			if (hv_q[o] && (ORD_W'(o) >= ord_q)) begin
				stop_ok = 1'b1;
				stop_o = ORD_W'(o);
			end
		end
	end

	// Sweep address and buddy pair for the merge step.
	assign blk_n = CNT_W'(1) << lo_q;
	assign sw_a = {1'b0, p_q} + cnt_q;
	assign mg_odd = |(p_q & blk_n[PAGE_W-1:0]);
	assign mg_lh = mg_odd ? (p_q - blk_n[PAGE_W-1:0]) : p_q;
	assign mg_rh = mg_odd ? {1'b0, p_q} : ({1'b0, p_q} + blk_n);

	// Memory port control for each state.
	always_comb begin
		f_we = 1'b0; f_wa = '0; f_wd = 1'b0;
		o_we = 1'b0; o_wa = '0; o_wd = '0;
		n_we = 1'b0; n_wa = '0; n_wd = '0;
		v_we = 1'b0; v_wa = '0; v_wd = '0;
		pi_ra = p_q;
		lk_ra = ln_q;
		case (state_q)
			S_CLR: begin
				f_we = 1'b1; f_wa = cnt_q[PAGE_W-1:0]; f_wd = 1'b1;
				o_we = 1'b1; o_wa = cnt_q[PAGE_W-1:0];
				o_wd = (cnt_q == '0) ? TOP_ORDER : '0;
				n_we = 1'b1; n_wa = cnt_q[PAGE_W-1:0];
				v_we = 1'b1; v_wa = cnt_q[PAGE_W-1:0];
			end
			S_ASPL1: begin
				o_we = 1'b1; o_wa = lh_q; o_wd = lo_q - ORD_W'(1);
			end
			S_ASPL2: begin
				o_we = 1'b1; o_wa = rh_q; o_wd = lo_q;
			end
			S_SWRD: pi_ra = sw_a[PAGE_W-1:0];
			S_SWWR: begin
				f_we = 1'b1; f_wa = sw_a[PAGE_W-1:0]; f_wd = func_q;
			end
			S_M0: pi_ra = mg_lh;
			S_M1: pi_ra = rh_q;
			S_M3: begin
				o_we = 1'b1; o_wa = rh_q; o_wd = '0;
			end
			S_M4: begin
				o_we = 1'b1; o_wa = lh_q; o_wd = lo_q + ORD_W'(1);
			end
			S_RM1: begin
				n_we = 1'b1; n_wa = prv_rd; n_wd = nxt_rd;
				v_we = 1'b1; v_wa = nxt_rd; v_wd = prv_rd;
			end
			S_AD0: begin
				lk_ra = head_cur;
				if (!hv_q[lo_q]) begin
					n_we = 1'b1; n_wa = ln_q; n_wd = ln_q;
					v_we = 1'b1; v_wa = ln_q; v_wd = ln_q;
				end
			end
			S_AD1: begin
				v_we = 1'b1; v_wa = ln_q; v_wd = prv_rd;
				n_we = 1'b1; n_wa = prv_rd; n_wd = ln_q;
			end
			S_AD2: begin
				n_we = 1'b1; n_wa = ln_q; n_wd = head_cur;
				v_we = 1'b1; v_wa = head_cur; v_wd = ln_q;
			end
			default: ;
		endcase
	end

	// Page memories with registered read data.
	always_ff @(posedge clk) begin
		if (f_we) fre_mem[f_wa] <= f_wd;
		if (o_we) ord_mem[o_wa] <= o_wd;
		if (n_we) nxt_mem[n_wa] <= n_wd;
		if (v_we) prv_mem[v_wa] <= v_wd;
		fre_rd <= fre_mem[pi_ra];
		ord_rd <= ord_mem[pi_ra];
		nxt_rd <= nxt_mem[lk_ra];
		prv_rd <= prv_mem[lk_ra];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ret_q <= S_IDLE;
			func_q <= 1'b0;
			quota_q <= 1'b0;
			ord_q <= '0;
			lo_q <= '0;
			lord_q <= '0;
			lfree_q <= 1'b0;
			lh_q <= '0;
			rh_q <= '0;
			p_q <= '0;
			ln_q <= '0;
			cnt_q <= '0;
			alloc_q <= '0;
			used_q <= '0;
			limit_q <= '0;
			hv_q <= ORDER_COUNT'(1) << TOP_ORDER;
			for (int o = 0; o < ORDER_COUNT; o++) head_q[o] <= '0;
			st_q <= ST_OK;
			ridx_q <= '0;
			rord_q <= '0;
			done_q <= 1'b0;
			status_q <= ST_OK;
			result_index_q <= '0;
			result_order_q <= '0;
			free_pages_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (quota_limit_we) limit_q <= quota_limit_bytes;
			case (state_q)
				S_CLR: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(PAGE_COUNT - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						func_q <= func;
						quota_q <= use_quota;
						ord_q <= req_ord;
						p_q <= block_index;
						state_q <= (func == FUNC_FREE) ? S_F0 : S_CHK;
					end
				end
				S_CHK: begin
					ridx_q <= '0;
					rord_q <= '0;
					if (q_fail) begin
						st_q <= ST_QUOTA;
						state_q <= S_FIN;
					end else if (ord_q >= ORD_W'(ORDER_COUNT) || !stop_ok) begin
						st_q <= ST_NOFREE;
						state_q <= S_FIN;
					end else begin
						lo_q <= stop_o;
						state_q <= S_AHEAD;
					end
				end
				S_AHEAD: begin
					lh_q <= head_cur;
					state_q <= S_ASPLIT;
				end
				S_ASPLIT: begin
					ln_q <= lh_q;
					ret_q <= (lo_q > ord_q) ? S_ASPL1 : S_ASW0;
					state_q <= S_RM0;
				end
				S_ASPL1: begin
					lo_q <= lo_q - ORD_W'(1);
					rh_q <= lh_q + PAGE_W'(blk_n >> 1);
					state_q <= S_ASPL2;
				end
				S_ASPL2: begin
					ln_q <= lh_q;
					ret_q <= S_ASPL3;
					state_q <= S_AD0;
				end
				S_ASPL3: begin
					ln_q <= rh_q;
					ret_q <= S_ASPLIT;
					state_q <= S_AD0;
				end
				S_ASW0: begin
					p_q <= lh_q;
					cnt_q <= '0;
					state_q <= S_SWRD;
				end
				S_F0: state_q <= S_F1;
				S_F1: begin
					ridx_q <= '0;
					rord_q <= '0;
					if (fre_rd) begin
						st_q <= ST_DFREE;
						state_q <= S_FIN;
					end else begin
						lo_q <= idx_n;
						if (quota_q) begin
							used_q <= (used_q >= QUOTA_W'(blk_b)) ?
								used_q - QUOTA_W'(blk_b) : '0;
						end
						cnt_q <= '0;
						state_q <= S_SWRD;
					end
				end
				// Per page: read its flag, then count and write.
				S_SWRD: begin
					if (cnt_q == blk_n || sw_a[PAGE_W]) state_q <= S_SWEND;
					else state_q <= S_SWWR;
				end
				S_SWWR: begin
					if (func_q == FUNC_ALLOC) begin
						if (fre_rd) alloc_q <= alloc_q + CNT_W'(1);
					end else if (!fre_rd && alloc_q != '0) begin
						alloc_q <= alloc_q - CNT_W'(1);
					end
					cnt_q <= cnt_q + CNT_W'(1);
					state_q <= S_SWRD;
				end
				S_SWEND: begin
					if (func_q == FUNC_ALLOC) begin
						if (quota_q) used_q <= used_q + QUOTA_W'(blk_b);
						st_q <= ST_OK;
						ridx_q <= lh_q;
						rord_q <= lo_q;
						state_q <= S_FIN;
					end else begin
						state_q <= S_M0;
					end
				end
				// Merge with the buddy while both halves are free of equal order.
				S_M0: begin
					lh_q <= mg_lh;
					rh_q <= mg_rh[PAGE_W-1:0];
					if (lo_q + ORD_W'(1) >= ORD_W'(ORDER_COUNT) || mg_rh[PAGE_W])
						state_q <= S_MEND;
					else
						state_q <= S_M1;
				end
				S_M1: begin
					lfree_q <= fre_rd;
					lord_q <= ord_rd;
					state_q <= S_M2;
				end
				S_M2: begin
					if (!lfree_q || !fre_rd || lord_q != ord_rd || lord_q != lo_q) begin
						state_q <= S_MEND;
					end else begin
						ln_q <= (p_q == lh_q) ? rh_q : lh_q;
						ret_q <= S_M3;
						state_q <= S_RM0;
					end
				end
				S_M3: state_q <= S_M4;
				S_M4: begin
					lo_q <= lo_q + ORD_W'(1);
					p_q <= lh_q;
					state_q <= S_M0;
				end
				S_MEND: begin
					ln_q <= p_q;
					ret_q <= S_FDONE;
					state_q <= S_AD0;
				end
				S_FDONE: begin
					st_q <= ST_OK;
					ridx_q <= '0;
					rord_q <= lo_q;
					state_q <= S_FIN;
				end
				// List removal of ln_q from order lo_q.
				S_RM0: begin
					state_q <= hv_q[lo_q] ? S_RM1 : ret_q;
				end
				S_RM1: begin
					if (head_cur == ln_q) begin
						if (nxt_rd == ln_q) hv_q[lo_q] <= 1'b0;
						else head_q[lo_q] <= nxt_rd;
					end
					state_q <= ret_q;
				end
				// List insertion of ln_q at the tail of order lo_q.
				S_AD0: begin
					if (!hv_q[lo_q]) begin
						head_q[lo_q] <= ln_q;
						hv_q[lo_q] <= 1'b1;
						state_q <= ret_q;
					end else begin
						state_q <= S_AD1;
					end
				end
				S_AD1: state_q <= S_AD2;
				S_AD2: state_q <= ret_q;
				S_FIN: begin
					done_q <= 1'b1;
					status_q <= st_q;
					result_index_q <= ridx_q;
					result_order_q <= rord_q;
					free_pages_q <= CNT_W'(PAGE_COUNT) - alloc_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign result_index = result_index_q;
	assign result_order = result_order_q;
	assign free_pages = free_pages_q;

endmodule

// ===== tb/tb_buddy_page_allocator_unit.sv =====
// Self-checking testbench of the buddy page allocator: random and directed words against a predictor.
`timescale 1ns / 1ps

module tb_buddy_page_allocator_unit;
	import bpa_pkg::*;

	typedef struct {
		logic                f;
		logic [REQ_W-1:0]    req;
		logic [PAGE_W-1:0]   blk;
		logic                q;
		bit                  drain;
	} cmd_t;

	typedef struct {
		logic [STAT_W-1:0]   st;
		logic [PAGE_W-1:0]   idx;
		logic [ORD_W-1:0]    ord;
		logic [CNT_W-1:0]    fp;
	} reply_t;

	typedef struct {
		logic [PAGE_W-1:0]   head;
		logic [ORD_W-1:0]    ord;
		logic                q;
	} block_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start, busy, func, use_quota, done;
	logic [REQ_W-1:0] request_bytes;
	logic [PAGE_W-1:0] block_index;
	logic quota_limit_we = 1'b0;
	logic [QUOTA_W-1:0] quota_limit_bytes = '0;
	logic [STAT_W-1:0] status;
	logic [PAGE_W-1:0] result_index;
	logic [ORD_W-1:0] result_order;
	logic [CNT_W-1:0] free_pages;

	cmd_t cmd_q[$];
	reply_t reply_q[$];
	block_t live_q[$];
	int errors = 0;
	int issued = 0;
	int answered = 0;
	int gap = 0;
	int calm = 0;

	// Predictor state: per-order free lists and per-page memories.
	bit                hv[ORDER_COUNT];
	logic [PAGE_W-1:0] lhead[ORDER_COUNT];
	logic [PAGE_W-1:0] nxt[PAGE_COUNT];
	logic [PAGE_W-1:0] prv[PAGE_COUNT];
	bit                nw[PAGE_COUNT];
	bit                pw[PAGE_COUNT];
	logic [ORD_W-1:0]  pord[PAGE_COUNT];
	bit                pfree[PAGE_COUNT];
	int unsigned       alloc_pages;
	logic [31:0]       qused;
	logic [31:0]       qlimit;
	bit                touched_unwritten;

	// Snapshot used to undo a word that would read a never-written link.
	bit                s_hv[ORDER_COUNT];
	logic [PAGE_W-1:0] s_lhead[ORDER_COUNT];
	logic [PAGE_W-1:0] s_nxt[PAGE_COUNT];
	logic [PAGE_W-1:0] s_prv[PAGE_COUNT];
	bit                s_nw[PAGE_COUNT];
	bit                s_pw[PAGE_COUNT];
	logic [ORD_W-1:0]  s_pord[PAGE_COUNT];
	bit                s_pfree[PAGE_COUNT];
	int unsigned       s_alloc_pages;
	logic [31:0]       s_qused;

	buddy_page_allocator_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.request_bytes(request_bytes), .block_index(block_index), .use_quota(use_quota),
		.quota_limit_we(quota_limit_we), .quota_limit_bytes(quota_limit_bytes),
		.done(done), .status(status), .result_index(result_index),
		.result_order(result_order), .free_pages(free_pages)
	);

	always #5 clk = ~clk;

	function automatic logic [PAGE_W-1:0] rd_next(int n);
		if (!nw[n]) touched_unwritten = 1'b1;
		return nxt[n];
	endfunction

	function automatic logic [PAGE_W-1:0] rd_prev(int n);
		if (!pw[n]) touched_unwritten = 1'b1;
		return prv[n];
	endfunction

	// Append a block head at the tail of its order's list.
	function automatic void list_push(int o, int n);
		logic [PAGE_W-1:0] h, t;
		if (!hv[o]) begin
			nxt[n] = n; prv[n] = n; nw[n] = 1; pw[n] = 1;
			lhead[o] = n; hv[o] = 1;
			return;
		end
		h = lhead[o];
		t = rd_prev(h);
		prv[n] = t; pw[n] = 1;
		nxt[t] = n; nw[t] = 1;
		nxt[n] = h; nw[n] = 1;
		prv[h] = n; pw[h] = 1;
	endfunction

	function automatic void list_unlink(int o, int n);
		logic [PAGE_W-1:0] nx, pv;
		if (!hv[o]) return;
		nx = rd_next(n);
		pv = rd_prev(n);
		nxt[pv] = nx; nw[pv] = 1;
		prv[nx] = pv; pw[nx] = 1;
		if (lhead[o] == n) begin
			if (nx == n) hv[o] = 0;
			else lhead[o] = nx;
		end
	endfunction

	function automatic reply_t make_reply(logic [STAT_W-1:0] st, int idx, int ord);
		reply_t r;
		r.st = st;
		r.idx = PAGE_W'(idx);
		r.ord = ORD_W'(ord);
		r.fp = CNT_W'(PAGE_COUNT - alloc_pages);
		return r;
	endfunction

	function automatic reply_t buddy_alloc(logic [REQ_W-1:0] req, logic q);
		longint unsigned blk_bytes;
		int order, stop, lh, rh;
		blk_bytes = PAGE_BYTES;
		order = 0;
		while (blk_bytes < req) begin
			blk_bytes = blk_bytes << 1;
			order++;
		end
		if (q) begin
			if (qlimit < qused || blk_bytes > longint'(qlimit - qused))
				return make_reply(ST_QUOTA, 0, 0);
		end
		if (order >= ORDER_COUNT) return make_reply(ST_NOFREE, 0, 0);
		stop = order;
		while (stop < ORDER_COUNT && !hv[stop]) stop++;
		if (stop >= ORDER_COUNT) return make_reply(ST_NOFREE, 0, 0);
		lh = lhead[stop];
		// Split the found block down to the requested order.
		while (stop > order) begin
			list_unlink(stop, lh);
			stop--;
			pord[lh] = ORD_W'(stop);
			rh = lh + (1 << stop);
			if (rh < PAGE_COUNT) pord[rh] = ORD_W'(stop);
			list_push(stop, lh);
			list_push(stop, rh);
		end
		list_unlink(stop, lh);
		for (int i = 0; i < (1 << order) && lh + i < PAGE_COUNT; i++) begin
			if (pfree[lh + i]) alloc_pages++;
			pfree[lh + i] = 0;
		end
		if (q) qused = qused + 32'(blk_bytes);
		return make_reply(ST_OK, lh, order);
	endfunction

	function automatic reply_t buddy_free(int p, logic q);
		int idx, n, lh, rh;
		longint unsigned bytes;
		if (pfree[p]) return make_reply(ST_DFREE, 0, 0);
		idx = pord[p];
		if (idx >= ORDER_COUNT) idx = ORDER_COUNT - 1;
		n = 1 << idx;
		if (q) begin
			bytes = longint'(PAGE_BYTES) << idx;
			if (longint'(qused) >= bytes) qused = qused - 32'(bytes);
			else qused = 0;
		end
		for (int i = 0; i < n && p + i < PAGE_COUNT; i++) begin
			if (!pfree[p + i] && alloc_pages > 0) alloc_pages--;
			pfree[p + i] = 1;
		end
		// Merge with free buddies of equal order as far up as possible.
		forever begin
			n = 1 << idx;
			lh = p;
			rh = p;
			if ((p >> idx) & 1) lh = p - n;
			else rh = p + n;
			if (idx + 1 >= ORDER_COUNT || rh >= PAGE_COUNT) break;
			if (!pfree[lh] || !pfree[rh]) break;
			if (pord[lh] != pord[rh] || pord[lh] != idx) break;
			list_unlink(idx, (p == lh) ? rh : lh);
			pord[rh] = 0;
			pord[lh] = ORD_W'(idx + 1);
			idx++;
			p = lh;
		end
		list_push(idx, p);
		return make_reply(ST_OK, 0, idx);
	endfunction

	// Predict one word and queue it, unless it would read a link never written.
	task automatic send_word(logic f, logic [REQ_W-1:0] req, logic [PAGE_W-1:0] blk,
			logic q, bit drain);
		cmd_t c;
		reply_t r;
		block_t b;
		s_hv = hv; s_lhead = lhead; s_nxt = nxt; s_prv = prv; s_nw = nw; s_pw = pw;
		s_pord = pord; s_pfree = pfree; s_alloc_pages = alloc_pages; s_qused = qused;
		touched_unwritten = 0;
		if (f == FUNC_ALLOC) r = buddy_alloc(req, q);
		else r = buddy_free(blk, q);
		if (touched_unwritten) begin
			hv = s_hv; lhead = s_lhead; nxt = s_nxt; prv = s_prv; nw = s_nw; pw = s_pw;
			pord = s_pord; pfree = s_pfree; alloc_pages = s_alloc_pages; qused = s_qused;
			return;
		end
		c.f = f; c.req = req; c.blk = blk; c.q = q; c.drain = drain;
		cmd_q.push_back(c);
		reply_q.push_back(r);
		if (f == FUNC_ALLOC && r.st == ST_OK) begin
			b.head = r.idx; b.ord = r.ord; b.q = q;
			live_q.push_back(b);
		end
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (cmd_q.size() != 0 || reply_q.size() != 0 || start || busy);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_limit(logic [31:0] v);
		wait_idle();
		quota_limit_we <= 1'b1;
		quota_limit_bytes <= v;
		@(posedge clk);
		quota_limit_we <= 1'b0;
		qlimit = v;
	endtask

	// Free a live block by its head, removing it from the live list.
	task automatic free_live(int k, bit drain);
		block_t b;
		b = live_q[k];
		live_q.delete(k);
		send_word(FUNC_FREE, REQ_W'($urandom), b.head, b.q, drain);
	endtask

	task automatic random_word();
		int r, k;
		logic [REQ_W-1:0] req;
		block_t b;
		r = $urandom_range(0, 99);
		if (live_q.size() == 0 || r < 52) begin
			k = $urandom_range(0, 99);
			if (k < 70) req = REQ_W'($urandom_range(0, 4 * PAGE_BYTES));
			else if (k < 92) req = REQ_W'($urandom_range(0, 64 * PAGE_BYTES));
			else req = REQ_W'($urandom);
			send_word(FUNC_ALLOC, req, PAGE_W'($urandom), 1'($urandom), r == 7);
		end else if (r < 93) begin
			free_live($urandom_range(0, live_q.size() - 1), r == 60);
		end else if (r < 97) begin
			// Free of a page inside a live block rather than its head.
			b = live_q[$urandom_range(0, live_q.size() - 1)];
			if (b.ord != 0)
				send_word(FUNC_FREE, REQ_W'($urandom),
					b.head + PAGE_W'($urandom_range(1, (1 << b.ord) - 1)), 1'($urandom), 0);
		end else begin
			send_word(FUNC_FREE, REQ_W'($urandom), PAGE_W'($urandom), 1'($urandom), 0);
		end
	endtask

	function automatic int pick_gap();
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) calm = 40;
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(30, 300);
	endfunction

	// Driver: presents queued words on start and counts accepted ones.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			func <= FUNC_ALLOC;
			request_bytes <= '0;
			block_index <= '0;
			use_quota <= 1'b0;
		end else begin
			if (start && !busy) issued++;
			if (!start || !busy) begin
				if (gap > 0) begin
					gap <= gap - 1;
					start <= 1'b0;
				end else if (cmd_q.size() > 0 && (!cmd_q[0].drain || issued == answered)) begin
					func <= cmd_q[0].f;
					request_bytes <= cmd_q[0].req;
					block_index <= cmd_q[0].blk;
					use_quota <= cmd_q[0].q;
					void'(cmd_q.pop_front());
					start <= 1'b1;
					gap <= pick_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result word against the oldest prediction.
	always @(posedge clk) begin
		reply_t w;
		if (arst_n && done) begin
			if (reply_q.size() == 0) begin
				$display("%0t: unexpected result word status=%0d index=%0d order=%0d free=%0d",
					$time, status, result_index, result_order, free_pages);
				errors++;
			end else begin
				w = reply_q.pop_front();
				answered++;
				if (status !== w.st) begin
					$display("%0t: status expected %0d actual %0d", $time, w.st, status);
					errors++;
				end
				if (result_index !== w.idx) begin
					$display("%0t: result_index expected %0d actual %0d",
						$time, w.idx, result_index);
					errors++;
				end
				if (result_order !== w.ord) begin
					$display("%0t: result_order expected %0d actual %0d",
						$time, w.ord, result_order);
					errors++;
				end
				if (free_pages !== w.fp) begin
					$display("%0t: free_pages expected %0d actual %0d", $time, w.fp, free_pages);
					errors++;
				end
			end
		end
	end

	initial begin
		#300ms;
		$display("tb_buddy_page_allocator_unit: FAIL");
		$finish;
	end

	initial begin
		logic [31:0] limits[5];
		// Reset state of the predictor: one free block of the top order.
		for (int i = 0; i < PAGE_COUNT; i++) begin
			nw[i] = 0; pw[i] = 0; pord[i] = 0; pfree[i] = 1; nxt[i] = 0; prv[i] = 0;
		end
		for (int o = 0; o < ORDER_COUNT; o++) begin
			hv[o] = 0; lhead[o] = 0;
		end
		pord[0] = TOP_ORDER;
		list_push(ORDER_COUNT - 1, 0);
		alloc_pages = 0; qused = 0; qlimit = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: sizes at the edges, full map, double free and quota refusal.
		write_limit(32'h0);
		send_word(FUNC_ALLOC, 23'd0, 10'd0, 1'b1, 0);
		send_word(FUNC_ALLOC, 23'd4194304, 10'd0, 1'b0, 0);
		send_word(FUNC_ALLOC, 23'd1, 10'd0, 1'b0, 0);
		send_word(FUNC_FREE, 23'd0, 10'd0, 1'b0, 0);
		send_word(FUNC_ALLOC, 23'h7FFFFF, 10'h3FF, 1'b0, 0);
		send_word(FUNC_FREE, 23'd0, 10'd5, 1'b0, 0);
		send_word(FUNC_ALLOC, 23'd0, 10'd0, 1'b0, 0);
		send_word(FUNC_ALLOC, 23'd4096, 10'd0, 1'b0, 0);
		send_word(FUNC_FREE, 23'd0, 10'd1, 1'b0, 0);
		send_word(FUNC_FREE, 23'd0, 10'd0, 1'b1, 1);
		send_word(FUNC_ALLOC, 23'd4097, 10'd0, 1'b0, 0);
		send_word(FUNC_ALLOC, 23'd16384, 10'd0, 1'b0, 0);
		send_word(FUNC_FREE, 23'd0, 10'd5, 1'b0, 0);
		send_word(FUNC_FREE, 23'd0, 10'd4, 1'b0, 0);
		send_word(FUNC_FREE, 23'd0, 10'd0, 1'b0, 0);
		write_limit(32'h0001_0000);
		send_word(FUNC_ALLOC, 23'd65536, 10'd0, 1'b1, 0);
		send_word(FUNC_ALLOC, 23'd1, 10'd0, 1'b1, 0);
		send_word(FUNC_FREE, 23'd0, 10'd0, 1'b1, 0);
		send_word(FUNC_ALLOC, 23'd8192, 10'd0, 1'b1, 0);
		send_word(FUNC_ALLOC, 23'd70000, 10'd0, 1'b1, 0);
		live_q.delete();
		live_q.push_back('{head: 10'd0, ord: 4'd1, q: 1'b1});

		// Random phases under different quota limits, extremes included.
		limits[0] = 32'hFFFF_FFFF;
		limits[1] = 32'h0;
		limits[2] = 32'h0008_0000;
		limits[3] = $urandom;
		limits[4] = 32'h0040_0000;
		for (int ph = 0; ph < 5; ph++) begin
			write_limit(limits[ph]);
			for (int n = 0; n < 250; n++) random_word();
		end

		wait_idle();
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("tb_buddy_page_allocator_unit: PASS");
		end else begin
			$display("tb_buddy_page_allocator_unit: FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/bpa_pkg.sv
src/buddy_page_allocator_unit.sv
tb/tb_buddy_page_allocator_unit.sv
